// File: design/bus_trace_replay_checker_unit_defines.svh
// Assertion macros used by the checker file of the trace replay checker.
`ifndef BUS_TRACE_REPLAY_CHECKER_UNIT_DEFINES_SVH
`define BUS_TRACE_REPLAY_CHECKER_UNIT_DEFINES_SVH

// Same-cycle implication, gated off while reset is active.
`define BTRC_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication; cons may itself start with a delay.
`define BTRC_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> cons) \
		else $error(msg);

`endif

// File: design/btrc_pkg.sv
// Package: types, codes and sizes of the bus trace replay checker.
`timescale 1ns / 1ps
package btrc_pkg;

	localparam int EVENT_DEPTH = 1024;
	localparam int AW          = $clog2(EVENT_DEPTH);
	localparam int CNT_W       = $clog2(EVENT_DEPTH + 1);

	localparam logic [1:0] ACT_APPEND = 2'd0;
	localparam logic [1:0] ACT_READ   = 2'd1;
	localparam logic [1:0] ACT_WRITE  = 2'd2;
	localparam logic [1:0] ACT_POLL   = 2'd3;

	localparam logic [1:0] KIND_READ  = 2'd0;
	localparam logic [1:0] KIND_WRITE = 2'd1;
	localparam logic [1:0] KIND_IRQ   = 2'd2;
	localparam logic [1:0] KIND_STOP  = 2'd3;

	localparam logic [2:0] STAT_OK        = 3'd0;
	localparam logic [2:0] STAT_PAST_END  = 3'd1;
	localparam logic [2:0] STAT_STOP      = 3'd2;
	localparam logic [2:0] STAT_KIND      = 3'd3;
	localparam logic [2:0] STAT_MISMATCH  = 3'd4;
	localparam logic [2:0] STAT_UNCHECKED = 3'd5;
	localparam logic [2:0] STAT_NO_IRQ    = 3'd6;
	localparam logic [2:0] STAT_FULL      = 3'd7;

	typedef enum logic {
		S_IDLE,
		S_EXEC
	} state_t;

	typedef struct packed {
		logic [1:0]  action;
		logic        restart;
		logic [1:0]  event_kind;
		logic [31:0] address;
		logic [31:0] data_value;
		logic [63:0] stamp;
	} req_t;

	typedef struct packed {
		logic [31:0]      read_data;
		logic             irq_valid;
		logic [2:0]       status;
		logic             diverged;
		logic [2:0]       first_divergence;
		logic [CNT_W-1:0] divergence_index;
		logic [63:0]      current_time;
		logic [CNT_W-1:0] cursor_position;
	} rsp_t;

	// One stored trace event, one memory word.
	typedef struct packed {
		logic [1:0]  kind;
		logic [31:0] address;
		logic [31:0] value;
		logic [63:0] stamp;
	} entry_t;

	// Decision of the match unit for the request in flight.
	typedef struct packed {
		logic [2:0]  status;
		logic        do_write;
		logic        consume;
		logic        latch;
		logic        irq_valid;
		logic [31:0] read_data;
	} match_t;

endpackage

// File: design/btrc_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps
module btrc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// File: design/btrc_match.sv
// Match unit: compares a request with the trace event at the cursor.
`timescale 1ns / 1ps
module btrc_match import btrc_pkg::*; (
	input  req_t             req,
	input  entry_t           entry,
	input  logic [CNT_W-1:0] cursor,
	input  logic [CNT_W-1:0] count_base,
	input  logic             check_writes,
	output match_t           m
);

	logic       past_end;
	logic [1:0] want_kind;
	logic       is_write;

	assign past_end  = (cursor >= count_base);
	assign is_write  = (req.action == ACT_WRITE);
	assign want_kind = is_write ? KIND_WRITE : KIND_READ;

	always_comb begin
		m = '0;
		unique case (req.action)
			ACT_APPEND: begin
				if (count_base >= CNT_W'(EVENT_DEPTH)) begin
					m.status = STAT_FULL;
				end else begin
					m.do_write = 1'b1;
				end
			end
			ACT_READ, ACT_WRITE: begin
				priority if (is_write && !check_writes) begin
					m.status = STAT_UNCHECKED;
				end else if (past_end) begin
					m.status = STAT_PAST_END;
				end else if (entry.kind == KIND_STOP) begin
					m.status = STAT_STOP;
				end else if (entry.kind != want_kind) begin
					m.status = STAT_KIND;
				end else if (entry.address != req.address ||
						(is_write && entry.value != req.data_value)) begin
					m.status = STAT_MISMATCH;
				end else begin
					m.consume   = 1'b1;
					m.read_data = is_write ? 32'd0 : entry.value;
				end
				m.latch = (m.status == STAT_PAST_END) || (m.status == STAT_STOP) ||
					(m.status == STAT_KIND) || (m.status == STAT_MISMATCH);
			end
			ACT_POLL: begin
				if (!past_end && entry.kind == KIND_IRQ) begin
					m.consume   = 1'b1;
					m.irq_valid = 1'b1;
					m.read_data = entry.address;
				end else begin
					m.status = STAT_NO_IRQ;
				end
			end
			default: m = '0;
		endcase
	end

endmodule

// File: design/bus_trace_replay_checker_unit.sv
// Top level of the bus trace replay checker: control, state registers, trace memory.
`timescale 1ns / 1ps
// Replays a recorded bus trace against live firmware accesses. A request is
// taken when start is high and busy is low; its result shows on result for
// exactly one cycle with done high, from the result register written in the
// execute state, and the receiver cannot stall it. busy covers only the
// execute cycle, so a new request can be taken in the cycle that shows the
// previous result; the pace is set by the single trace memory read (issued at
// the request edge, at the cursor) followed by the compare-and-update step.
// Appends write the event in the execute cycle. There is no clearing pass:
// only entries below the event count are ever used. check_writes is to be
// written by the user through cfg_we/cfg_wdata while idle; the block has no guard.
module bus_trace_replay_checker_unit import btrc_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	output logic busy,
	input  req_t request,
	output logic done,
	output rsp_t result,
	input  logic cfg_we,
	input  logic cfg_wdata
);

	state_t           state_q, state_d;
	req_t             req_q;
	entry_t           entry_rd;
	match_t           m;

	logic             check_writes_q;
	logic [CNT_W-1:0] count_q, cursor_q, div_pos_q;
	logic [63:0]      now_q;
	logic [2:0]       div_code_q;

	// next values of the architectural state
	logic [CNT_W-1:0] count_base, count_d, cursor_d, div_pos_d;
	logic [63:0]      now_d;
	logic [2:0]       div_code_d;
	logic             clear;
	logic             accept;
	logic             exec;
	logic             done_q;
	rsp_t             result_q;

	assign accept = start && (state_q == S_IDLE);
	assign exec   = (state_q == S_EXEC);
	assign busy   = exec;
	assign done   = done_q;
	assign result = result_q;

	// FSM
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: if (start) state_d = S_EXEC;
			S_EXEC: state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			req_q <= request;
		end
	end

	// trace memory: read at the cursor on accept, append write in execute
	btrc_ram #(
		.WIDTH ($bits(entry_t)),
		.DEPTH (EVENT_DEPTH)
	) u_trace (
		.clk   (clk),
		.we    (exec && m.do_write),
		.waddr (count_base[AW-1:0]),
		.wdata ({req_q.event_kind, req_q.address, req_q.data_value, req_q.stamp}),
		.re    (accept),
		.raddr (cursor_q[AW-1:0]),
		.rdata (entry_rd)
	);

	// restart on an append wipes the trace before the new event goes in
	assign clear      = (req_q.action == ACT_APPEND) && req_q.restart;
	assign count_base = clear ? '0 : count_q;

	btrc_match u_match (
		.req          (req_q),
		.entry        (entry_rd),
		.cursor       (cursor_q),
		.count_base   (count_base),
		.check_writes (check_writes_q),
		.m            (m)
	);

	always_comb begin
		count_d    = m.do_write ? count_base + CNT_W'(1) : count_base;
		cursor_d   = clear ? '0 : cursor_q;
		now_d      = clear ? '0 : now_q;
		div_code_d = clear ? '0 : div_code_q;
		div_pos_d  = clear ? '0 : div_pos_q;
		if (m.consume) begin
			now_d    = entry_rd.stamp;
			cursor_d = cursor_q + CNT_W'(1);
		end
		// only the first divergence is kept
		if (m.latch && div_code_q == STAT_OK) begin
			div_code_d = m.status;
			div_pos_d  = cursor_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			check_writes_q <= 1'b0;
			count_q        <= '0;
			cursor_q       <= '0;
			now_q          <= '0;
			div_code_q     <= '0;
			div_pos_q      <= '0;
			done_q         <= 1'b0;
		end else begin
			if (cfg_we) begin
				check_writes_q <= cfg_wdata;
			end
			if (exec) begin
				count_q    <= count_d;
				cursor_q   <= cursor_d;
				now_q      <= now_d;
				div_code_q <= div_code_d;
				div_pos_q  <= div_pos_d;
			end
			done_q <= exec;
		end
	end

	// result register, shown for one cycle with done
	always_ff @(posedge clk) begin
		if (exec) begin
			result_q.read_data        <= m.read_data;
			result_q.irq_valid        <= m.irq_valid;
			result_q.status           <= m.status;
			result_q.diverged         <= (div_code_d != STAT_OK);
			result_q.first_divergence <= div_code_d;
			result_q.divergence_index <= div_pos_d;
			result_q.current_time     <= now_d;
			result_q.cursor_position  <= cursor_d;
		end
	end

endmodule

// File: design/btrc_checker.sv
// Port-level assertions for the trace replay checker, bound to the top level.
`timescale 1ns / 1ps
`include "bus_trace_replay_checker_unit_defines.svh"
module btrc_checker import btrc_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input logic done,
	input rsp_t result
);

	`BTRC_ASSERT_NEXT(a_req_busy, start && !busy, busy, "request did not raise busy")
	`BTRC_ASSERT_NEXT(a_req_done, start && !busy, ##1 done, "result not two cycles after request")
	`BTRC_ASSERT_NOW(a_done_idle, done, !busy, "result shown while busy")
	`BTRC_ASSERT_NOW(a_div_flag, done, result.diverged == (result.first_divergence != STAT_OK), "diverged flag disagrees with latched code")

endmodule

bind bus_trace_replay_checker_unit btrc_checker u_btrc_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.done   (done),
	.result (result)
);
